>>> rtl/dsg_pkg.sv
// Package: widths, sequencer states, register indexes and ALU operation codes.
package dsg_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    CFG_P = 2'd0,
    CFG_Q = 2'd1,
    CFG_H = 2'd2,
    CFG_X = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_MOD = 2'd0,  // a mod m, restoring, one bit a step
    OP_DIV = 2'd1,  // a / m, quotient and remainder
    OP_MUL = 2'd2   // a * b mod m, shift and add, one bit a step
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T_DIV,
    S_G_BASE,
    S_G_LOOP,
    S_G_MUL,
    S_G_SQR,
    S_Y_LOOP,
    S_Y_MUL,
    S_Y_SQR,
    S_Z_LOOP,
    S_Z_MUL,
    S_Z_SQR,
    S_R_MOD,
    S_H_MOD,
    S_I_DIV,
    S_I_MUL,
    S_I_STEP,
    S_XR_MUL,
    S_S_MUL,
    S_DONE
  } state_t;

endpackage

>>> rtl/dsg_alu.sv
// Shared serial modular unit: reduce, divide, and multiply modulo m.
module dsg_alu (
  input  logic             clk,
  input  logic             rst_n,
  input  dsg_pkg::alu_ctl_t ctl,
  input  dsg_pkg::word_t   a,
  input  dsg_pkg::word_t   b,
  input  dsg_pkg::word_t   m,
  output logic             busy,
  output logic             done,
  output dsg_pkg::word_t   quot,
  output dsg_pkg::word_t   res
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  dsg_pkg::alu_op_t          op_r, op_nxt;
  logic [dsg_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  dsg_pkg::word_t            sh_r, sh_nxt;   // dividend or multiplier, MSB first
  dsg_pkg::word_t            ad_r, ad_nxt;   // multiplicand, reduced
  dsg_pkg::word_t            acc_r, acc_nxt;
  dsg_pkg::word_t            q_r, q_nxt;
  logic [dsg_pkg::WIDTH:0]   dbl;
  logic [dsg_pkg::WIDTH:0]   dbl_b;
  logic [dsg_pkg::WIDTH:0]   sum;
  logic                      ge;

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    ad_r  <= ad_nxt;
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
  end

  // One step: double acc (shifting in a bit for reduce), then one conditional subtract.
  // For multiply a second add of ad follows in the same step, reduced by one compare.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    ad_nxt   = ad_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    dbl      = '0;
    dbl_b    = '0;
    sum      = '0;
    ge       = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      cnt_nxt  = dsg_pkg::CNT_W'(dsg_pkg::WIDTH);
      acc_nxt  = '0;
      q_nxt    = '0;
      ad_nxt   = b;
      sh_nxt   = a;
    end else if (busy_r) begin
      if (op_r == dsg_pkg::OP_MUL) begin
        // multiplicand is already reduced by the sequencer
        dbl   = {acc_r, 1'b0};
        dbl_b = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
        sum   = dbl_b + (sh_r[dsg_pkg::WIDTH-1] ? {1'b0, ad_r} : '0);
        acc_nxt = (sum >= {1'b0, m}) ? dsg_pkg::word_t'(sum - {1'b0, m})
                                     : dsg_pkg::word_t'(sum);
      end else begin
        dbl = {acc_r, sh_r[dsg_pkg::WIDTH-1]};
        ge  = dbl >= {1'b0, m};
        acc_nxt = ge ? dsg_pkg::word_t'(dbl - {1'b0, m}) : dsg_pkg::word_t'(dbl);
        q_nxt   = {q_r[dsg_pkg::WIDTH-2:0], ge};
      end
      sh_nxt  = {sh_r[dsg_pkg::WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dsg_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign res  = acc_r;

endmodule

>>> rtl/dsg_seq.sv
// Sequencer: steps the exponentiations, the reductions and the inverse through the unit.
module dsg_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  dsg_pkg::word_t    nonce_k,
  input  dsg_pkg::word_t    message_hash,
  input  dsg_pkg::word_t    prime_p,
  input  dsg_pkg::word_t    prime_q,
  input  dsg_pkg::word_t    generator_seed,
  input  dsg_pkg::word_t    private_key,
  input  logic              alu_busy,
  input  logic              alu_done,
  input  dsg_pkg::word_t    alu_quot,
  input  dsg_pkg::word_t    alu_res,
  output dsg_pkg::alu_ctl_t alu_ctl,
  output dsg_pkg::word_t    alu_a,
  output dsg_pkg::word_t    alu_b,
  output dsg_pkg::word_t    alu_m,
  output logic              idle,
  output logic              fin,
  output dsg_pkg::word_t    res_r,
  output dsg_pkg::word_t    res_s,
  output dsg_pkg::word_t    res_g,
  output dsg_pkg::word_t    res_y,
  output logic              res_status
);

  dsg_pkg::state_t st_r, st_nxt;
  logic            issued_r, issued_nxt;  // operation launched in this state
  dsg_pkg::word_t  k_r, k_nxt;
  dsg_pkg::word_t  hsh_r, hsh_nxt;
  dsg_pkg::word_t  e_r, e_nxt;            // exponent being consumed
  dsg_pkg::word_t  base_r, base_nxt;
  dsg_pkg::word_t  acc_r, acc_nxt;
  dsg_pkg::word_t  g_r, g_nxt;
  dsg_pkg::word_t  y_r, y_nxt;
  dsg_pkg::word_t  r_r, r_nxt;
  dsg_pkg::word_t  s_r, s_nxt;
  dsg_pkg::word_t  hm_r, hm_nxt;
  dsg_pkg::word_t  r0_r, r0_nxt, r1_r, r1_nxt;
  dsg_pkg::word_t  t0_r, t0_nxt, t1_r, t1_nxt;
  dsg_pkg::word_t  qt_r, qt_nxt;
  logic            st_bad_r, st_bad_nxt;
  logic            pbad;                  // modulus p below 2
  logic            qz;
  dsg_pkg::word_t  pm1;
  logic [dsg_pkg::WIDTH:0] hx;

  assign pbad = (prime_p[dsg_pkg::WIDTH-1:1] == '0);
  assign qz   = (prime_q == '0);
  assign pm1  = prime_p - 1'b1;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= dsg_pkg::S_IDLE;
      issued_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      issued_r <= issued_nxt;
    end
    k_r <= k_nxt; hsh_r <= hsh_nxt; e_r <= e_nxt; base_r <= base_nxt;
    acc_r <= acc_nxt; g_r <= g_nxt; y_r <= y_nxt; r_r <= r_nxt;
    s_r <= s_nxt; hm_r <= hm_nxt; r0_r <= r0_nxt; r1_r <= r1_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; qt_r <= qt_nxt; st_bad_r <= st_bad_nxt;
  end

  // Next state and unit control
  always_comb begin
    st_nxt = st_r; issued_nxt = issued_r;
    k_nxt = k_r; hsh_nxt = hsh_r; e_nxt = e_r; base_nxt = base_r;
    acc_nxt = acc_r; g_nxt = g_r; y_nxt = y_r; r_nxt = r_r; s_nxt = s_r;
    hm_nxt = hm_r; r0_nxt = r0_r; r1_nxt = r1_r; t0_nxt = t0_r; t1_nxt = t1_r;
    qt_nxt = qt_r; st_bad_nxt = st_bad_r;
    alu_ctl = '{start: 1'b0, op: dsg_pkg::OP_MOD};
    alu_a = '0; alu_b = '0; alu_m = prime_p;
    fin = 1'b0;
    hx = '0;
    case (st_r)
      dsg_pkg::S_IDLE: begin
        if (go) begin
          k_nxt = nonce_k; hsh_nxt = message_hash;
          issued_nxt = 1'b0;
          st_nxt = dsg_pkg::S_T_DIV;
        end
      end
      // exponent (p-1)/q
      dsg_pkg::S_T_DIV: begin
        alu_a = pm1; alu_m = prime_q;
        alu_ctl = '{start: !issued_r, op: dsg_pkg::OP_DIV};
        if (qz || prime_p == '0) begin
          e_nxt = '0; st_nxt = dsg_pkg::S_G_BASE;
        end else if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (alu_done) begin
          e_nxt = alu_quot; issued_nxt = 1'b0; st_nxt = dsg_pkg::S_G_BASE;
        end
      end
      // base h mod p
      dsg_pkg::S_G_BASE: begin
        alu_a = generator_seed;
        alu_ctl = '{start: !issued_r && !pbad, op: dsg_pkg::OP_MOD};
        acc_nxt = dsg_pkg::word_t'(1);
        if (pbad) begin
          base_nxt = '0; st_nxt = dsg_pkg::S_G_LOOP;
        end else if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (alu_done) begin
          base_nxt = alu_res; issued_nxt = 1'b0; st_nxt = dsg_pkg::S_G_LOOP;
        end
      end
      dsg_pkg::S_G_LOOP, dsg_pkg::S_Y_LOOP, dsg_pkg::S_Z_LOOP: begin
        if (pbad || e_r == '0) begin
          case (st_r)
            dsg_pkg::S_G_LOOP: begin
              g_nxt = pbad ? '0 : acc_r;
              base_nxt = pbad ? '0 : acc_r;
              e_nxt = private_key; acc_nxt = dsg_pkg::word_t'(1);
              st_nxt = dsg_pkg::S_Y_LOOP;
            end
            dsg_pkg::S_Y_LOOP: begin
              y_nxt = pbad ? '0 : acc_r;
              base_nxt = g_r;
              e_nxt = k_r; acc_nxt = dsg_pkg::word_t'(1);
              st_nxt = dsg_pkg::S_Z_LOOP;
            end
            default: begin
              acc_nxt = pbad ? '0 : acc_r;
              st_nxt = dsg_pkg::S_R_MOD;
            end
          endcase
        end else if (e_r[0]) begin
          st_nxt = (st_r == dsg_pkg::S_G_LOOP) ? dsg_pkg::S_G_MUL :
                   (st_r == dsg_pkg::S_Y_LOOP) ? dsg_pkg::S_Y_MUL : dsg_pkg::S_Z_MUL;
        end else begin
          st_nxt = (st_r == dsg_pkg::S_G_LOOP) ? dsg_pkg::S_G_SQR :
                   (st_r == dsg_pkg::S_Y_LOOP) ? dsg_pkg::S_Y_SQR : dsg_pkg::S_Z_SQR;
        end
      end
      dsg_pkg::S_G_MUL, dsg_pkg::S_Y_MUL, dsg_pkg::S_Z_MUL: begin
        alu_a = acc_r; alu_b = base_r;
        alu_ctl = '{start: !issued_r, op: dsg_pkg::OP_MUL};
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (alu_done) begin
          acc_nxt = alu_res; issued_nxt = 1'b0;
          st_nxt = (st_r == dsg_pkg::S_G_MUL) ? dsg_pkg::S_G_SQR :
                   (st_r == dsg_pkg::S_Y_MUL) ? dsg_pkg::S_Y_SQR : dsg_pkg::S_Z_SQR;
        end
      end
      dsg_pkg::S_G_SQR, dsg_pkg::S_Y_SQR, dsg_pkg::S_Z_SQR: begin
        alu_a = base_r; alu_b = base_r;
        alu_ctl = '{start: !issued_r, op: dsg_pkg::OP_MUL};
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (alu_done) begin
          base_nxt = alu_res; issued_nxt = 1'b0;
          e_nxt = {1'b0, e_r[dsg_pkg::WIDTH-1:1]};
          st_nxt = (st_r == dsg_pkg::S_G_SQR) ? dsg_pkg::S_G_LOOP :
                   (st_r == dsg_pkg::S_Y_SQR) ? dsg_pkg::S_Y_LOOP : dsg_pkg::S_Z_LOOP;
        end
      end
      // r = z mod q
      dsg_pkg::S_R_MOD: begin
        alu_a = acc_r; alu_m = prime_q;
        alu_ctl = '{start: !issued_r && !qz, op: dsg_pkg::OP_MOD};
        st_bad_nxt = 1'b1; s_nxt = '0;
        if (qz) begin
          r_nxt = '0; st_nxt = dsg_pkg::S_DONE;
        end else if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (alu_done) begin
          r_nxt = alu_res; issued_nxt = 1'b0;
          st_nxt = (k_r == '0 || k_r >= prime_q) ? dsg_pkg::S_DONE : dsg_pkg::S_H_MOD;
        end
      end
      dsg_pkg::S_H_MOD: begin
        alu_a = hsh_r; alu_m = prime_q;
        alu_ctl = '{start: !issued_r, op: dsg_pkg::OP_MOD};
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (alu_done) begin
          hm_nxt = alu_res; issued_nxt = 1'b0;
          r0_nxt = prime_q; r1_nxt = k_r; t0_nxt = '0; t1_nxt = dsg_pkg::word_t'(1);
          st_nxt = dsg_pkg::S_I_DIV;
        end
      end
      // extended Euclid: quotient, then qt*t1 mod q, then update
      dsg_pkg::S_I_DIV: begin
        alu_a = r0_r; alu_m = r1_r;
        alu_ctl = '{start: !issued_r && r1_r != '0, op: dsg_pkg::OP_DIV};
        if (r1_r == '0) begin
          st_nxt = (r0_r == dsg_pkg::word_t'(1)) ? dsg_pkg::S_XR_MUL : dsg_pkg::S_DONE;
        end else if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (alu_done) begin
          qt_nxt = alu_quot; r0_nxt = r1_r; r1_nxt = alu_res;
          issued_nxt = 1'b0; st_nxt = dsg_pkg::S_I_MUL;
        end
      end
      dsg_pkg::S_I_MUL: begin
        // qt < q here except on the first step, where qt may be reduced by mod first
        alu_a = qt_r; alu_b = t1_r; alu_m = prime_q;
        alu_ctl = '{start: !issued_r && qt_r < prime_q, op: dsg_pkg::OP_MUL};
        if (qt_r >= prime_q) begin
          alu_ctl = '{start: !issued_r, op: dsg_pkg::OP_MOD};
          if (!issued_r) issued_nxt = 1'b1;
          else if (alu_done) begin
            qt_nxt = alu_res; issued_nxt = 1'b0;
          end
        end else if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (alu_done) begin
          qt_nxt = alu_res; issued_nxt = 1'b0; st_nxt = dsg_pkg::S_I_STEP;
        end
      end
      dsg_pkg::S_I_STEP: begin
        t0_nxt = t1_r;
        t1_nxt = (t0_r >= qt_r) ? t0_r - qt_r : t0_r + (prime_q - qt_r);
        st_nxt = dsg_pkg::S_I_DIV;
      end
      dsg_pkg::S_XR_MUL: begin
        // x itself may be above q: reduce it first into qt_r
        alu_m = prime_q;
        if (!issued_r && !st_bad_r) begin
          alu_a = private_key;
          alu_ctl = '{start: 1'b1, op: dsg_pkg::OP_MOD};
          issued_nxt = 1'b1;
        end else if (st_bad_r) begin
          alu_a = private_key;
          alu_ctl = '{start: 1'b0, op: dsg_pkg::OP_MOD};
          if (alu_done) begin
            qt_nxt = alu_res; st_bad_nxt = 1'b0; issued_nxt = 1'b0;
          end else if (!issued_r) begin
            alu_ctl = '{start: 1'b1, op: dsg_pkg::OP_MOD};
            issued_nxt = 1'b1;
          end
        end else begin
          alu_a = qt_r; alu_b = r_r;
          alu_ctl = '{start: 1'b0, op: dsg_pkg::OP_MUL};
          if (alu_done) begin
            hx = {1'b0, hm_r} + {1'b0, alu_res};
            hm_nxt = (hx >= {1'b0, prime_q}) ? dsg_pkg::word_t'(hx - {1'b0, prime_q})
                                            : dsg_pkg::word_t'(hx);
            issued_nxt = 1'b0; st_nxt = dsg_pkg::S_S_MUL;
          end
        end
        // once x mod q is ready, launch the product
        if (!st_bad_r && issued_r == 1'b0 && st_r == dsg_pkg::S_XR_MUL && !alu_busy
            && !alu_done) begin
          alu_a = qt_r; alu_b = r_r;
          alu_ctl = '{start: 1'b1, op: dsg_pkg::OP_MUL};
          issued_nxt = 1'b1;
        end
      end
      dsg_pkg::S_S_MUL: begin
        alu_a = t0_r; alu_b = hm_r; alu_m = prime_q;
        alu_ctl = '{start: !issued_r, op: dsg_pkg::OP_MUL};
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (alu_done) begin
          s_nxt = alu_res; st_bad_nxt = 1'b0; issued_nxt = 1'b0;
          st_nxt = dsg_pkg::S_DONE;
        end
      end
      dsg_pkg::S_DONE: begin
        fin = 1'b1;
        issued_nxt = 1'b0;
        st_nxt = dsg_pkg::S_IDLE;
      end
      default: st_nxt = dsg_pkg::S_IDLE;
    endcase
  end

  assign idle       = (st_r == dsg_pkg::S_IDLE);
  assign res_r      = r_r;
  assign res_s      = s_r;
  assign res_g      = g_r;
  assign res_y      = y_r;
  assign res_status = st_bad_r;

endmodule

>>> rtl/dsa_signature_generator.sv
// Top level: configuration registers, input capture, result register and handshakes.
// DSA signing over 32-bit groups. Each transfer on the input channel starts a run of
// three square-and-multiply exponentiations modulo p (generator, public key, g^k),
// reductions modulo q and, for 0 < k < q, an extended-Euclid inverse of k, all on
// one shared serial unit. Every modular product, reduction or division holds the
// sequencer through a launch, WIDTH steps of the unit and the take of the result.
// in_ready is low throughout a run. The result waits in an output register, and the
// next item is taken once it has been transferred. Configuration must be written only
// while idle; the block does not enforce this. cfg_index is two bits wide, so every
// write selects one of the four registers.
module dsa_signature_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dsg_pkg::word_t       in_nonce_k,
  input  dsg_pkg::word_t       in_message_hash,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dsg_pkg::word_t       out_signature_r,
  output dsg_pkg::word_t       out_signature_s,
  output dsg_pkg::word_t       out_generator_g,
  output dsg_pkg::word_t       out_public_key_y,
  output logic                 out_status
);

  dsg_pkg::word_t    p_r, q_r, h_r, x_r;
  logic              ov_r, ov_nxt;
  dsg_pkg::word_t    or_r, os_r, og_r, oy_r;
  logic              ost_r;
  logic              go, idle, fin;
  dsg_pkg::alu_ctl_t alu_ctl;
  dsg_pkg::word_t    alu_a, alu_b, alu_m, alu_quot, alu_res;
  logic              alu_busy, alu_done;
  dsg_pkg::word_t    res_r, res_s, res_g, res_y;
  logic              res_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle && !ov_r;
  assign go        = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= dsg_pkg::word_t'(23);
      q_r <= dsg_pkg::word_t'(11);
      h_r <= dsg_pkg::word_t'(2);
      x_r <= dsg_pkg::word_t'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        dsg_pkg::CFG_P: p_r <= cfg_data;
        dsg_pkg::CFG_Q: q_r <= cfg_data;
        dsg_pkg::CFG_H: h_r <= cfg_data;
        dsg_pkg::CFG_X: x_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the result until transferred
  always_comb begin
    ov_nxt = ov_r;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    if (fin) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= ov_nxt;
    if (fin) begin
      or_r <= res_r; os_r <= res_s; og_r <= res_g; oy_r <= res_y; ost_r <= res_status;
    end
  end

  dsg_alu u_alu (
    .clk (clk), .rst_n (rst_n), .ctl (alu_ctl), .a (alu_a), .b (alu_b), .m (alu_m),
    .busy (alu_busy), .done (alu_done), .quot (alu_quot), .res (alu_res)
  );

  dsg_seq u_seq (
    .clk (clk), .rst_n (rst_n), .go (go),
    .nonce_k (in_nonce_k), .message_hash (in_message_hash),
    .prime_p (p_r), .prime_q (q_r), .generator_seed (h_r), .private_key (x_r),
    .alu_busy (alu_busy), .alu_done (alu_done), .alu_quot (alu_quot), .alu_res (alu_res),
    .alu_ctl (alu_ctl), .alu_a (alu_a), .alu_b (alu_b), .alu_m (alu_m),
    .idle (idle), .fin (fin),
    .res_r (res_r), .res_s (res_s), .res_g (res_g), .res_y (res_y),
    .res_status (res_status)
  );

  assign out_valid        = ov_r;
  assign out_signature_r  = or_r;
  assign out_signature_s  = os_r;
  assign out_generator_g  = og_r;
  assign out_public_key_y = oy_r;
  assign out_status       = ost_r;

endmodule

>>> tb/sv/tb.sv
// Testbench for the DSA signature generator: directed and random signing with a scoreboard.
module tb;

  localparam int unsigned LIMIT_CYCLES = 12_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    dsg_pkg::word_t nonce;
    dsg_pkg::word_t hash;
  } sign_req_t;

  typedef struct packed {
    dsg_pkg::word_t r;
    dsg_pkg::word_t s;
    dsg_pkg::word_t g;
    dsg_pkg::word_t y;
    logic           status;
  } signature_t;

  typedef struct packed {
    dsg_pkg::cfg_idx_t idx;
    dsg_pkg::word_t    data;
  } reg_write_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_index = '0;
  logic [31:0]    cfg_data = '0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  dsg_pkg::word_t in_nonce_k = '0;
  dsg_pkg::word_t in_message_hash = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  dsg_pkg::word_t out_signature_r;
  dsg_pkg::word_t out_signature_s;
  dsg_pkg::word_t out_generator_g;
  dsg_pkg::word_t out_public_key_y;
  logic           out_status;

  // Predictor copy of the registers
  logic [63:0] reg_p = 64'd23;
  logic [63:0] reg_q = 64'd11;
  logic [63:0] reg_h = 64'd2;
  logic [63:0] reg_x = 64'd1;

  sign_req_t  pending_reqs[$];
  reg_write_t pending_writes[$];
  signature_t expected_sigs[$];
  int unsigned mismatches = 0;
  int unsigned sigs_seen = 0;
  int unsigned error_sigs = 0;
  int unsigned cycle_count = 0;
  bit          stall_free = 1'b0;
  bit          cfg_phase = 1'b0;

  dsa_signature_generator u_dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = a * b;
    return 64'(prod % m);
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    if (m < 2) return 0;
    acc = 1;
    base = base % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, base, m);
      base = mulmod(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // Compute one signature from the current register values
  function automatic signature_t sign_message(sign_req_t req);
    signature_t res;
    logic [63:0] t, g, z, r0, r1, r2, t0, t1, t2, qt, sum;
    res = '0;
    res.status = 1'b1;
    t = (reg_q != 0) ? (reg_p - 1) / reg_q : 0;
    if (reg_p == 0) t = 0;
    g = powmod(reg_h, t, reg_p);
    res.g = dsg_pkg::word_t'(g);
    res.y = dsg_pkg::word_t'(powmod(g, reg_x, reg_p));
    z = powmod(g, {32'd0, req.nonce}, reg_p);
    if (reg_q != 0) begin
      res.r = dsg_pkg::word_t'(z % reg_q);
      if (req.nonce != 0 && req.nonce < reg_q) begin
        // extended Euclid for the nonce inverse
        r0 = reg_q; r1 = req.nonce; t0 = 0; t1 = 1;
        while (r1 != 0) begin
          qt = r0 / r1;
          r2 = r0 - qt * r1;
          t2 = (t0 + reg_q - mulmod(qt, t1, reg_q)) % reg_q;
          r0 = r1; r1 = r2; t0 = t1; t1 = t2;
        end
        if (r0 == 1) begin
          sum = ({32'd0, req.hash} % reg_q + mulmod(reg_x, res.r, reg_q)) % reg_q;
          res.s = dsg_pkg::word_t'(mulmod(t0, sum, reg_q));
          res.status = 1'b0;
        end
      end
    end
    return res;
  endfunction

  function automatic bit idle_now();
    return !stall_free && ($urandom_range(99) < 23);
  endfunction

  // Configuration driver: present writes only in a configuration phase
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (dsg_pkg::cfg_idx_t'(cfg_index))
          dsg_pkg::CFG_P: reg_p <= {32'd0, cfg_data};
          dsg_pkg::CFG_Q: reg_q <= {32'd0, cfg_data};
          dsg_pkg::CFG_H: reg_h <= {32'd0, cfg_data};
          dsg_pkg::CFG_X: reg_x <= {32'd0, cfg_data};
          default: ;
        endcase
        void'(pending_writes.pop_front());
      end
      if (!cfg_valid || cfg_ready) begin
        if (cfg_phase && pending_writes.size() > 0) begin
          cfg_valid <= 1'b1;
          cfg_index <= pending_writes[0].idx;
          cfg_data  <= pending_writes[0].data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Input driver: feed queued requests with random gaps
  always @(posedge clk) begin
    if (rst_n && !cfg_phase) begin
      if (in_valid && in_ready) begin
        expected_sigs.push_back(sign_message(pending_reqs.pop_front()));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && !idle_now() && !(in_valid && in_ready)) begin
          in_valid        <= 1'b1;
          in_nonce_k      <= pending_reqs[0].nonce;
          in_message_hash <= pending_reqs[0].hash;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each signature transfer with the oldest prediction
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      out_ready <= !idle_now();
      if (out_valid && out_ready) begin
        signature_t got, want;
        got = '{out_signature_r, out_signature_s, out_generator_g, out_public_key_y,
                out_status};
        sigs_seen <= sigs_seen + 1;
        if (got.status) error_sigs <= error_sigs + 1;
        if (expected_sigs.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected signature transfer r=%h", got.r);
        end else begin
          want = expected_sigs.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp r=%h s=%h g=%h y=%h st=%b got r=%h s=%h g=%h y=%h st=%b",
                       want.r, want.s, want.g, want.y, want.status,
                       got.r, got.s, got.g, got.y, got.status);
          end
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("dsa_signature_generator verification failed");
      $finish;
    end
  end

  task automatic add_req(dsg_pkg::word_t k, dsg_pkg::word_t h);
    pending_reqs.push_back('{k, h});
  endtask

  task automatic add_write(dsg_pkg::cfg_idx_t i, dsg_pkg::word_t d);
    pending_writes.push_back('{i, d});
  endtask

  // Apply queued writes with the block idle, then hand over to the input driver
  task automatic run_writes();
    wait (pending_reqs.size() == 0 && expected_sigs.size() == 0 && !in_valid);
    @(posedge clk);
    cfg_phase = 1'b1;
    wait (pending_writes.size() == 0);
    @(posedge clk);
    cfg_phase = 1'b0;
  endtask

  task automatic rand_phase(int n, dsg_pkg::word_t q);
    int sel;
    dsg_pkg::word_t k;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      if (sel == 0) k = 0;
      else if (sel == 1) k = $urandom();
      else if (sel == 2) k = q;
      else k = (q > 1) ? $urandom_range(q - 1, 1) : 1;
      add_req(k, $urandom());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: directed nonce extremes
    add_req(0, 0);
    add_req(1, 32'hFFFF_FFFF);
    add_req(10, 5);
    add_req(11, 7);
    add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(5, 32'h8000_0000);
    wait (pending_reqs.size() == 0 && expected_sigs.size() == 0);

    // Large prime p with q = 5, key with every bit set but the lowest
    add_write(dsg_pkg::CFG_P, 32'hFFFF_FFFB);
    add_write(dsg_pkg::CFG_Q, 32'd5);
    add_write(dsg_pkg::CFG_H, 32'hFFFF_FFFF);
    add_write(dsg_pkg::CFG_X, 32'hFFFF_FFFE);
    run_writes();
    add_req(4, 32'hFFFF_FFFF);
    add_req(1, 0);
    rand_phase(30, 5);

    // Composite q: nonce sharing a factor, and degenerate p and q
    add_write(dsg_pkg::CFG_P, 32'd1);
    add_write(dsg_pkg::CFG_Q, 32'd12);
    run_writes();
    add_req(6, 3);
    add_req(5, 3);
    add_write(dsg_pkg::CFG_P, 32'd0);
    run_writes();
    add_req(5, 3);
    add_write(dsg_pkg::CFG_Q, 32'd0);
    add_write(dsg_pkg::CFG_P, 32'd23);
    run_writes();
    add_req(3, 3);

    // Classic group, no idling stretch
    add_write(dsg_pkg::CFG_P, 32'd2_147_483_647);
    add_write(dsg_pkg::CFG_Q, 32'd2_147_483_647);
    add_write(dsg_pkg::CFG_H, 32'd7);
    add_write(dsg_pkg::CFG_X, 32'h1234_5677);
    run_writes();
    stall_free = 1'b1;
    rand_phase(30, 32'd2_147_483_647);
    wait (pending_reqs.size() == 0 && expected_sigs.size() == 0);
    stall_free = 1'b0;

    // Random configurations
    for (int c = 0; c < 4; c++) begin
      add_write(dsg_pkg::CFG_P, $urandom());
      add_write(dsg_pkg::CFG_Q, $urandom());
      add_write(dsg_pkg::CFG_H, $urandom());
      add_write(dsg_pkg::CFG_X, $urandom());
      run_writes();
      rand_phase(15, reg_q[31:0]);
    end

    wait (pending_reqs.size() == 0 && expected_sigs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("signed %0d messages, %0d with status set, over ten register settings",
             sigs_seen, error_sigs);
    if (mismatches == 0 && expected_sigs.size() == 0)
      $display("dsa_signature_generator verification clean");
    else
      $display("dsa_signature_generator verification failed");
    $finish;
  end

endmodule
